// File: sv/sfs_pkg.sv
`default_nettype none
package sfs_pkg;

	// Request codes on req_type
	typedef logic [1:0] req_t;
	localparam req_t REQ_TICK = 2'd0;
	localparam req_t REQ_PLAY = 2'd1;
	localparam req_t REQ_STOP = 2'd2;

	// Configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_CELL_COUNT    = 3'd0;
	localparam cfg_idx_t CFG_CELLS_PER_ROW = 3'd1;
	localparam cfg_idx_t CFG_CELL_WIDTH    = 3'd2;
	localparam cfg_idx_t CFG_CELL_HEIGHT   = 3'd3;
	localparam cfg_idx_t CFG_Y_OFFSET      = 3'd4;
	localparam cfg_idx_t CFG_CELL_PADDING  = 3'd5;
	localparam cfg_idx_t CFG_FRAME_PERIOD  = 3'd6;

	// Restoring divider: 9-bit dividend, one quotient bit per cycle
	localparam int DivSteps = 9;
	localparam int DivCntW  = $clog2(DivSteps);

	// Cell placement sequencer phases
	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_COL,
		SEQ_MOD,
		SEQ_NEXT
	} seq_state_t;

	// Placement results handed from the sequencer to the top level
	typedef struct packed {
		logic       done;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] nxt_frame;
		logic [7:0] nxt_col;
		logic [7:0] nxt_row;
	} place_t;

	// One result item
	typedef struct packed {
		logic        playing;
		logic [7:0]  frame;
		logic [19:0] x;
		logic [19:0] y;
	} result_t;

endpackage
`default_nettype wire

// File: sv/sfs_place.sv
`default_nettype none
// Recomputes cell placement after a register write, using one shared
// restoring divider:
//   COL : frame / cpr            -> row, column of the current frame
//   MOD : (frame + 1) % eff      -> frame that follows an out-of-range frame
//   NEXT: that frame / cpr       -> its row and column
module sfs_place import sfs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [7:0] frame,
	input  wire logic [7:0] cpr,
	input  wire logic [7:0] eff,
	output logic            busy,
	output place_t          res
);

	seq_state_t          state_q, state_d;
	logic [DivCntW-1:0]  cnt_q;
	logic [8:0]          dvd_q;
	logic [7:0]          rem_q;
	logic [8:0]          quo_q;
	logic                done_q;
	logic [7:0]          col_q, row_q, nf_q, nc_q, nr_q;

	logic [7:0]          divisor;
	logic [8:0]          rem_sh;
	logic                ge;
	logic [7:0]          rem_nx;
	logic [8:0]          quo_nx;
	logic                last;

	// One divider step
	assign rem_sh = {rem_q, dvd_q[8]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
	assign quo_nx = {quo_q[7:0], ge};
	assign last   = cnt_q == DivCntW'(DivSteps - 1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SEQ_IDLE: state_d = SEQ_IDLE;
			SEQ_COL:  if (last) state_d = SEQ_MOD;
			SEQ_MOD:  if (last) state_d = SEQ_NEXT;
			SEQ_NEXT: if (last) state_d = SEQ_IDLE;
			default:  state_d = SEQ_IDLE;
		endcase
		if (start)
			state_d = SEQ_COL;
	end

	// Outputs of the sequencer
	always_comb begin
		busy    = 1'b1;
		divisor = cpr;
		case (state_q)
			SEQ_IDLE: busy = 1'b0;
			SEQ_MOD:  divisor = eff;
			default:  divisor = cpr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == SEQ_NEXT) && last && !start;
			if (start || last)
				cnt_q <= '0;
			else if (busy)
				cnt_q <= cnt_q + DivCntW'(1);
		end
	end

	// Divider datapath and stored results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= {1'b0, frame};
		end else if (busy) begin
			if (last) begin
				rem_q <= '0;
				case (state_q)
					SEQ_COL: begin
						col_q <= rem_nx;
						row_q <= quo_nx[7:0];
						dvd_q <= 9'(frame) + 9'd1;
					end
					SEQ_MOD: begin
						nf_q  <= rem_nx;
						dvd_q <= {1'b0, rem_nx};
					end
					SEQ_NEXT: begin
						nc_q <= rem_nx;
						nr_q <= quo_nx[7:0];
					end
					default: dvd_q <= dvd_q;
				endcase
			end else begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				dvd_q <= {dvd_q[7:0], 1'b0};
			end
		end
	end

	assign res = '{done: done_q, col: col_q, row: row_q,
		nxt_frame: nf_q, nxt_col: nc_q, nxt_row: nr_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DivCntW'(DivSteps - 1))
		else $error("divider step count out of range");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rem_q < divisor)
		else $error("partial remainder not below divisor");

	a_done_after_next: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == SEQ_NEXT) && state_q == SEQ_IDLE)
		else $error("placement done without a finished last phase");

endmodule
`default_nettype wire

// File: sv/sprite_frame_sequencer.sv
`default_nettype none
// Channel   Dir  Handshake                 Payload
// in        in   in_valid / in_ready       req_type, loop_mode
// out       out  out_valid / out_ready     is_playing, frame_number, cell_x, cell_y
// cfg       in   cfg_we (no wait)          cfg_index, cfg_data
//
// One item per cycle while in_ready is high: the state update and both coordinate
// multiplies are done in the accept cycle and the result is written to a two-entry
// output buffer. in_ready stays high while one result waits; it drops with both
// entries full. A register write starts a placement pass (three 9-step divisions
// in sfs_place) whose results load in the cycle after it ends; in_ready is low in
// the write cycle, during the pass and as results load. Reset needs no such pass.
// Reset restores register defaults and stops the animation at frame 0.
module sprite_frame_sequencer import sfs_pkg::*; #(
	parameter int MAX_CELLS = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic        loop_mode,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_playing,
	output logic [7:0]       frame_number,
	output logic [19:0]      cell_x,
	output logic [19:0]      cell_y,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam logic [7:0] MaxCnt = 8'(MAX_CELLS);

	// Configuration registers
	logic [7:0]  cell_count_q, cells_per_row_q, cell_padding_q;
	logic [11:0] cell_width_q, cell_height_q, y_offset_q;
	logic [15:0] frame_period_q;

	// Animation state
	logic        running_q, looping_q;
	logic [16:0] elapsed_q;
	logic [7:0]  frame_q, col_q, row_q;

	logic        running_d, looping_d;
	logic [16:0] elapsed_d;
	logic [7:0]  frame_d, col_d, row_d;

	logic [7:0]  eff, cpr_eff;
	logic        stale, busy, accept;
	place_t      place;

	// Output buffer
	result_t     buf_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  fifo_cnt_q;
	logic        pop;
	result_t     res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q    <= 8'd1;
			cells_per_row_q <= 8'd1;
			cell_width_q    <= 12'd16;
			cell_height_q   <= 12'd16;
			y_offset_q      <= 12'd0;
			cell_padding_q  <= 8'd0;
			frame_period_q  <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CELL_COUNT:    cell_count_q    <= cfg_data[7:0];
				CFG_CELLS_PER_ROW: cells_per_row_q <= cfg_data[7:0];
				CFG_CELL_WIDTH:    cell_width_q    <= cfg_data[11:0];
				CFG_CELL_HEIGHT:   cell_height_q   <= cfg_data[11:0];
				CFG_Y_OFFSET:      y_offset_q      <= cfg_data[11:0];
				CFG_CELL_PADDING:  cell_padding_q  <= cfg_data[7:0];
				CFG_FRAME_PERIOD:  frame_period_q  <= cfg_data;
				default:           cell_count_q    <= cell_count_q;
			endcase
		end
	end

	// Effective counts: zero acts as one, cell count clamps at the maximum
	assign eff = (cell_count_q == 8'd0) ? 8'd1 :
		(cell_count_q > MaxCnt) ? MaxCnt : cell_count_q;
	assign cpr_eff = (cells_per_row_q == 8'd0) ? 8'd1 : cells_per_row_q;
	// Frame left beyond the count by a register change
	assign stale = frame_q >= eff;

	sfs_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.frame  (frame_q),
		.cpr    (cpr_eff),
		.eff    (eff),
		.busy   (busy),
		.res    (place)
	);

	// Hold off in a write cycle, while placement runs or its results load, and with a full buffer
	assign in_ready = !busy && !place.done && !cfg_we && (fifo_cnt_q != 2'd2);
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	// Next animation state for the item being taken
	always_comb begin
		logic [16:0] inc;
		logic        wrap;
		logic [7:0]  nf, nc, nr;
		running_d = running_q;
		looping_d = looping_q;
		elapsed_d = elapsed_q;
		frame_d   = frame_q;
		col_d     = col_q;
		row_d     = row_q;
		inc  = (elapsed_q == '1) ? elapsed_q : elapsed_q + 17'd1;
		wrap = stale ? (place.nxt_frame == 8'd0) : (9'(frame_q) + 9'd1 == 9'(eff));
		if (stale) begin
			nf = place.nxt_frame;
			nc = place.nxt_col;
			nr = place.nxt_row;
		end else if (wrap) begin
			nf = 8'd0;
			nc = 8'd0;
			nr = 8'd0;
		end else if (col_q + 8'd1 == cpr_eff) begin
			nf = frame_q + 8'd1;
			nc = 8'd0;
			nr = row_q + 8'd1;
		end else begin
			nf = frame_q + 8'd1;
			nc = col_q + 8'd1;
			nr = row_q;
		end
		case (req_t'(req_type))
			REQ_PLAY: begin
				if (!running_q) begin
					looping_d = loop_mode;
					elapsed_d = '0;
					frame_d   = '0;
					col_d     = '0;
					row_d     = '0;
					running_d = 1'b1;
				end
			end
			REQ_STOP: running_d = 1'b0;
			REQ_TICK: begin
				if (running_q) begin
					if (inc > {1'b0, frame_period_q}) begin
						elapsed_d = '0;
						if (wrap && !looping_q) begin
							running_d = 1'b0;
						end else begin
							frame_d = nf;
							col_d   = nc;
							row_d   = nr;
						end
					end else begin
						elapsed_d = inc;
					end
				end
			end
			default: running_d = running_q;
		endcase
	end

	// Coordinates of the cell after the update
	always_comb begin
		logic [19:0] pad;
		pad = (frame_d != 8'd0) ? 20'(cell_padding_q) : 20'd0;
		res_d.playing = running_d;
		res_d.frame   = frame_d;
		res_d.x       = 20'(20'(col_d) * 20'(cell_width_q)) + pad;
		res_d.y       = 20'(y_offset_q) + 20'(20'(row_d) * 20'(cell_height_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			looping_q <= 1'b0;
			elapsed_q <= '0;
			frame_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (accept) begin
			running_q <= running_d;
			looping_q <= looping_d;
			elapsed_q <= elapsed_d;
			frame_q   <= frame_d;
			col_q     <= col_d;
			row_q     <= row_d;
		end else if (place.done) begin
			col_q <= place.col;
			row_q <= place.row;
		end
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (accept)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			fifo_cnt_q <= fifo_cnt_q + 2'(accept) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			buf_q[wr_ptr_q] <= res_d;
	end

	assign out_valid    = fifo_cnt_q != 2'd0;
	assign is_playing   = buf_q[rd_ptr_q].playing;
	assign frame_number = buf_q[rd_ptr_q].frame;
	assign cell_x       = buf_q[rd_ptr_q].x;
	assign cell_y       = buf_q[rd_ptr_q].y;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= 2'd2)
		else $error("output buffer overfilled");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy && !place.done)
		else $error("item taken during placement pass");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("no result after a transfer in");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !place.done |-> col_q < cpr_eff)
		else $error("column index outside its row");

endmodule
`default_nettype wire
